// ===== rtl/core/ipv_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv_pkg
// Types, character codes and helpers shared by the address text checker.
// ----------------------------------------------------------------------------
package ipv_pkg;

  localparam int unsigned ValW = 9;
  localparam logic [ValW-1:0] SatValue = 9'd256;
  localparam logic [ValW-1:0] MaxOctet = 9'd255;

  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharStar  = 8'h2a;

  typedef enum logic [1:0] {
    VER_UNK = 2'd0,
    VER_V4  = 2'd1,
    VER_V6  = 2'd2
  } version_e;

  typedef enum logic [2:0] {
    ST_INCOMPLETE = 3'd0,
    ST_V4_PART    = 3'd1,
    ST_V4         = 3'd2,
    ST_V6_PART    = 3'd3,
    ST_V6         = 3'd4,
    ST_ERROR      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    MODE_ANY   = 2'd0,
    MODE_V4    = 2'd1,
    MODE_V6    = 2'd2,
    MODE_PHONE = 2'd3
  } mode_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_phone_char(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h64)) ||
           ((c >= 8'h41) && (c <= 8'h44)) ||
           (c == CharComma) || (c == CharHash) || (c == CharStar);
  endfunction

endpackage

// ===== rtl/core/ip_address_text_validator_top.sv =====
// ----------------------------------------------------------------------------
// ip_address_text_validator_top
// Classifies an address string one character word at a time and filters it.
// ----------------------------------------------------------------------------
// result: the word of a character is registered and valid in the cycle after it is taken
// throughput: one character per cycle, set by the single result register;
//   input stalls only while a result is held by a stalled output
// reset: scan state cleared, filter mode set to any ip, no result pending
module ip_address_text_validator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          char_code_i,
  input  logic                first_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ipv_pkg::status_e    status_o,
  output logic                accepted_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i
);
  import ipv_pkg::*;

  mode_e          mode_q;
  version_e       ver_q, ver_c, ver_n, ver_d;
  logic [2:0]     len_q, len_c, len_n, len_d, len_inc;
  logic [3:0]     sep_q, sep_c, sep_n, sep_d, sep_inc;
  logic [ValW-1:0] val_q, val_c, val_n, val_d, dig_v;
  logic           dc_q, dc_c, dc_n, dc_d;
  logic           hex_q, hex_c, hex_n, hex_d;
  logic           lc_q, lc_c, lc_d;
  logic [1:0]     cp_q, cp_c, cp_d;
  logic           err_q, err_c, err_d;
  logic           pb_q, pb_c, pb_d;
  logic           sc_err, second_after_colon;
  logic [11:0]    prod;
  status_e        status_d, status_q;
  logic           acc_d, acc_q, out_valid_q;
  logic           in_accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // a start flag wipes the string state before the character is scanned
  always_comb begin
    ver_c = first_i ? VER_UNK : ver_q;
    len_c = first_i ? '0 : len_q;
    sep_c = first_i ? '0 : sep_q;
    val_c = first_i ? '0 : val_q;
    dc_c  = first_i ? 1'b0 : dc_q;
    hex_c = first_i ? 1'b0 : hex_q;
    lc_c  = first_i ? 1'b0 : lc_q;
    cp_c  = first_i ? '0 : cp_q;
    err_c = first_i ? 1'b0 : err_q;
    pb_c  = first_i ? 1'b0 : pb_q;
  end

  assign len_inc = len_c + 3'd1;
  assign sep_inc = sep_c + 4'd1;
  assign prod    = {3'b000, val_c} * 12'd10 + {8'h00, char_code_i[3:0]};
  assign dig_v   = (val_c >= SatValue) ? SatValue :
                   ((prod > {3'b000, SatValue}) ? SatValue : prod[ValW-1:0]);
  assign second_after_colon = (cp_c == 2'd1) && lc_c;

  always_comb begin
    ver_n  = ver_c;
    len_n  = len_c;
    sep_n  = sep_c;
    val_n  = val_c;
    dc_n   = dc_c;
    hex_n  = hex_c;
    sc_err = 1'b0;
    if (is_hex_letter(char_code_i)) begin
      len_n  = len_inc;
      val_n  = SatValue;
      sc_err = (ver_c == VER_V4) ||
               ((ver_c == VER_V6) && (second_after_colon || (len_inc > 3'd4)));
      if (ver_c == VER_UNK) ver_n = VER_V6;
      hex_n = 1'b1;
    end else if (is_digit(char_code_i)) begin
      len_n  = len_inc;
      val_n  = dig_v;
      sc_err = ((ver_c == VER_V4) && ((len_inc > 3'd3) || (dig_v > MaxOctet))) ||
               ((ver_c == VER_V6) && (second_after_colon || (len_inc > 3'd4))) ||
               ((ver_c == VER_UNK) && (len_inc > 3'd4));
      if ((ver_c == VER_UNK) && ((len_inc == 3'd4) || (dig_v > MaxOctet))) begin
        ver_n = VER_V6;
      end
    end else if (char_code_i == CharDot) begin
      sep_n  = sep_inc;
      sc_err = (len_c == 3'd0) ||
               ((ver_c == VER_V4) && (sep_inc > 4'd3)) ||
               ((ver_c == VER_V6) && ((sep_inc > 4'd6) || (len_c > 3'd3) ||
                                      (val_c > MaxOctet)));
      // dotted tail inside an ipv6 address restarts the separator count
      if ((ver_c == VER_V6) && !hex_c && (val_c <= MaxOctet)) begin
        ver_n = VER_V4;
        sep_n = 4'd1;
      end
      if ((ver_c == VER_UNK) && (val_c <= MaxOctet)) ver_n = VER_V4;
      len_n = '0;
      val_n = '0;
    end else if (char_code_i == CharColon) begin
      sep_n  = sep_inc;
      sc_err = (ver_c == VER_V4) || (sep_inc >= 4'd8) || ((len_c == 3'd0) && dc_c);
      if ((sep_inc > 4'd1) && (len_c == 3'd0)) dc_n = 1'b1;
      if (ver_c == VER_UNK) ver_n = VER_V6;
      len_n = '0;
      val_n = '0;
      hex_n = 1'b0;
    end else begin
      sc_err = 1'b1;
    end
  end

  always_comb begin
    ver_d = ver_c;
    len_d = len_c;
    sep_d = sep_c;
    val_d = val_c;
    dc_d  = dc_c;
    hex_d = hex_c;
    lc_d  = lc_c;
    cp_d  = cp_c;
    err_d = err_c;
    pb_d  = pb_c || !is_phone_char(char_code_i);
    if (!err_c) begin
      if (sc_err) begin
        err_d = 1'b1;
      end else begin
        ver_d = ver_n;
        len_d = len_n;
        sep_d = sep_n;
        val_d = val_n;
        dc_d  = dc_n;
        hex_d = hex_n;
      end
      if ((cp_c == 2'd0) && (char_code_i == CharColon)) lc_d = 1'b1;
      if (cp_c < 2'd3) cp_d = cp_c + 2'd1;
    end
  end

  always_comb begin
    if (err_d) begin
      status_d = ST_ERROR;
    end else if ((ver_d == VER_V4) && (sep_d == 4'd3) && (len_d != 3'd0)) begin
      status_d = ST_V4;
    end else if ((ver_d == VER_V6) && (len_d != 3'd0) && ((sep_d == 4'd8) || dc_d)) begin
      status_d = ST_V6;
    end else if (ver_d == VER_V4) begin
      status_d = ST_V4_PART;
    end else if (ver_d == VER_V6) begin
      status_d = ST_V6_PART;
    end else begin
      status_d = ST_INCOMPLETE;
    end
  end

  always_comb begin
    case (mode_q)
      MODE_ANY: acc_d = (status_d != ST_ERROR);
      MODE_V4:  acc_d = (status_d inside {ST_INCOMPLETE, ST_V4_PART, ST_V4});
      MODE_V6:  acc_d = (status_d inside {ST_INCOMPLETE, ST_V6_PART, ST_V6});
      default:  acc_d = !pb_d;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ANY;
      ver_q       <= VER_UNK;
      len_q       <= '0;
      sep_q       <= '0;
      val_q       <= '0;
      dc_q        <= 1'b0;
      hex_q       <= 1'b0;
      lc_q        <= 1'b0;
      cp_q        <= '0;
      err_q       <= 1'b0;
      pb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= mode_e'(cfg_wdata_i);
      if (in_accept) begin
        ver_q       <= ver_d;
        len_q       <= len_d;
        sep_q       <= sep_d;
        val_q       <= val_d;
        dc_q        <= dc_d;
        hex_q       <= hex_d;
        lc_q        <= lc_d;
        cp_q        <= cp_d;
        err_q       <= err_d;
        pb_q        <= pb_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, held while the output stalls
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q <= status_d;
      acc_q    <= acc_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign accepted_o  = acc_q;

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && in_accept && !first_i) |=> err_q)
    else $error("scan error cleared without a start flag");

  a_v4_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ver_q == VER_V4) |-> (sep_q <= 4'd3))
    else $error("ipv4 prefix with more than three dots");

  // a dotted tail may follow a double colon, so only the unknown version is ruled out
  a_dc_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc_q |-> (ver_q != VER_UNK))
    else $error("double colon in a prefix of unknown version");

  a_hex_v6: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_q |-> (ver_q == VER_V6))
    else $error("hex letter flag outside an ipv6 prefix");

endmodule
